FILE: rtl/rtc_cal_pkg.sv
package rtc_cal_pkg;

  localparam logic [1:0] KIND_TICK = 2'd0;
  localparam logic [1:0] KIND_SET  = 2'd1;

  localparam logic [5:0] SEC_MAX   = 6'd59;
  localparam logic [5:0] MIN_MAX   = 6'd59;
  localparam logic [4:0] HOUR_MAX  = 5'd23;
  localparam logic [5:0] MIN_WRAP  = 6'd60;
  localparam logic [5:0] HOUR_WRAP = 6'd24;
  localparam logic [3:0] MONTHS    = 4'd12;

  // 25 * INV25 == 1 (mod 2^16); y is a multiple of 25 exactly when y * INV25 <= DIV25_MAX
  localparam logic [15:0] INV25     = 16'h5C29;
  localparam logic [15:0] DIV25_MAX = 16'd2621;

  typedef struct packed {
    logic [1:0]  kind;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [15:0] year;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  hour_tens;
    logic [3:0]  hour_ones;
    logic [2:0]  minute_tens;
    logic [3:0]  minute_ones;
    logic [2:0]  second_tens;
    logic [3:0]  second_ones;
    logic [4:0]  cur_day;
    logic [3:0]  cur_month;
    logic [15:0] cur_year;
    logic        date_rejected;
  } out_item_t;

  typedef struct packed {
    logic tick;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } tod_t;

  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [15:0] year;
  } date_t;

  typedef struct packed {
    logic [2:0] tens;
    logic [3:0] ones;
  } bcd_t;

  // Gregorian rule: y%400 == 0 iff y%16 == 0 and y%25 == 0; y%100 == 0 iff y%4 == 0 and y%25 == 0
  function automatic logic is_leap(input logic [15:0] y);
    logic [15:0] p;
    logic        div25;
    p     = y * INV25;
    div25 = (p <= DIV25_MAX);
    return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'b0000));
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    unique case (m) inside
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      4'd2:                    len = leap ? 5'd29 : 5'd28;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic bcd_t to_bcd(input logic [5:0] v);
    bcd_t       d;
    logic [5:0] rem;
    if (v >= 6'd50)      d.tens = 3'd5;
    else if (v >= 6'd40) d.tens = 3'd4;
    else if (v >= 6'd30) d.tens = 3'd3;
    else if (v >= 6'd20) d.tens = 3'd2;
    else if (v >= 6'd10) d.tens = 3'd1;
    else                 d.tens = 3'd0;
    rem    = v - {d.tens, 3'b000} - {2'b00, d.tens, 1'b0};
    d.ones = rem[3:0];
    return d;
  endfunction

endpackage

FILE: rtl/rtc_cal_time.sv
module rtc_cal_time import rtc_cal_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       upd,
  input  cmd_t       cmd,
  input  logic [4:0] set_hour,
  input  logic [5:0] set_minute,
  output tod_t       tod_nxt,
  output logic       day_step
);

  tod_t       tod_r;
  logic       carry;
  logic [5:0] min_ld;
  logic [5:0] h_sum;
  logic [5:0] hour_ld;

  // load: fold minutes above 59 into the hour, then wrap hours above 23 by subtracting 24; the date is not advanced
  always_comb begin
    carry   = (set_minute >= MIN_WRAP);
    min_ld  = carry ? set_minute - MIN_WRAP : set_minute;
    h_sum   = {1'b0, set_hour} + {5'b00000, carry};
    hour_ld = (h_sum >= HOUR_WRAP) ? h_sum - HOUR_WRAP : h_sum;
  end

  assign day_step = cmd.tick && (tod_r.second == SEC_MAX) && (tod_r.minute == MIN_MAX)
                    && (tod_r.hour == HOUR_MAX);

  always_comb begin
    tod_nxt = tod_r;
    if (cmd.tick) begin
      if (tod_r.second == SEC_MAX) begin
        tod_nxt.second = '0;
        if (tod_r.minute == MIN_MAX) begin
          tod_nxt.minute = '0;
          tod_nxt.hour   = (tod_r.hour == HOUR_MAX) ? '0 : tod_r.hour + 5'd1;
        end else begin
          tod_nxt.minute = tod_r.minute + 6'd1;
        end
      end else begin
        tod_nxt.second = tod_r.second + 6'd1;
      end
    end else if (cmd.load) begin
      tod_nxt.hour   = hour_ld[4:0];
      tod_nxt.minute = min_ld;
      tod_nxt.second = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tod_r <= '0;
    end else if (upd) begin
      tod_r <= tod_nxt;
    end
  end

endmodule

FILE: rtl/rtc_cal_date.sv
module rtc_cal_date import rtc_cal_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        upd,
  input  cmd_t        cmd,
  input  logic        day_step,
  input  logic [4:0]  set_day,
  input  logic [3:0]  set_month,
  input  logic [15:0] set_year,
  output date_t       date_nxt,
  output logic        rejected
);

  date_t      date_r;
  logic [4:0] len_cur;
  logic [4:0] len_set;
  logic       set_ok;

  assign len_cur = month_len(date_r.month, is_leap(date_r.year));
  assign len_set = month_len(set_month, is_leap(set_year));
  assign set_ok  = (set_day != 5'd0) && (set_month != 4'd0) && (set_month <= MONTHS)
                   && (set_day <= len_set);
  assign rejected = cmd.load && !set_ok;

  always_comb begin
    date_nxt = date_r;
    if (day_step) begin
      if (date_r.day < len_cur) begin
        date_nxt.day = date_r.day + 5'd1;
      end else begin
        date_nxt.day = 5'd1;
        if (date_r.month >= MONTHS) begin
          date_nxt.month = 4'd1;
          date_nxt.year  = date_r.year + 16'd1;
        end else begin
          date_nxt.month = date_r.month + 4'd1;
        end
      end
    end else if (cmd.load && set_ok) begin
      date_nxt.day   = set_day;
      date_nxt.month = set_month;
      date_nxt.year  = set_year;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      date_r <= '{day: 5'd1, month: 4'd1, year: 16'd0};
    end else if (upd) begin
      date_r <= date_nxt;
    end
  end

endmodule

FILE: rtl/rtc_calendar_counter.sv
// Each accepted word's result is registered (in the skid while the output stalls).
// Throughput: one word per cycle while in_stall is low; the time and date counters
// update at the accepting edge. A two-entry output buffer (result register plus skid)
// keeps input flowing for one word while the output is stalled.
// Reset (synchronous, active low): time 00:00:00, date day 1 month 1 year 0, buffer empty.
module rtc_calendar_counter import rtc_cal_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  cmd_t      cmd;
  logic      acc;
  logic      take;
  logic      day_step;
  logic      rejected;
  tod_t      tod_nxt;
  date_t     date_nxt;
  bcd_t      h_bcd;
  bcd_t      m_bcd;
  bcd_t      s_bcd;
  out_item_t res;

  logic      out_valid_r, out_valid_nxt;
  logic      skid_v_r, skid_v_nxt;
  out_item_t out_data_r, out_data_nxt;
  out_item_t skid_data_r, skid_data_nxt;

  assign in_stall  = skid_v_r;
  assign acc       = in_valid && !in_stall;
  assign take      = out_valid_r && !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign cmd.tick = (in_data.kind == KIND_TICK);
  assign cmd.load = (in_data.kind == KIND_SET);

  rtc_cal_time u_time (
    .clk        (clk),
    .rst_n      (rst_n),
    .upd        (acc),
    .cmd        (cmd),
    .set_hour   (in_data.hour),
    .set_minute (in_data.minute),
    .tod_nxt    (tod_nxt),
    .day_step   (day_step)
  );

  rtc_cal_date u_date (
    .clk       (clk),
    .rst_n     (rst_n),
    .upd       (acc),
    .cmd       (cmd),
    .day_step  (day_step),
    .set_day   (in_data.day),
    .set_month (in_data.month),
    .set_year  (in_data.year),
    .date_nxt  (date_nxt),
    .rejected  (rejected)
  );

  always_comb begin
    h_bcd = to_bcd({1'b0, tod_nxt.hour});
    m_bcd = to_bcd(tod_nxt.minute);
    s_bcd = to_bcd(tod_nxt.second);
    res.hour_tens     = h_bcd.tens[1:0];
    res.hour_ones     = h_bcd.ones;
    res.minute_tens   = m_bcd.tens;
    res.minute_ones   = m_bcd.ones;
    res.second_tens   = s_bcd.tens;
    res.second_ones   = s_bcd.ones;
    res.cur_day       = date_nxt.day;
    res.cur_month     = date_nxt.month;
    res.cur_year      = date_nxt.year;
    res.date_rejected = rejected;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    skid_v_nxt    = skid_v_r;
    out_data_nxt  = out_data_r;
    skid_data_nxt = skid_data_r;
    if (skid_v_r) begin
      // drain the skid word into the result register
      if (take) begin
        out_data_nxt = skid_data_r;
        skid_v_nxt   = 1'b0;
      end
    end else if (acc) begin
      if (!out_valid_r || take) begin
        out_data_nxt  = res;
        out_valid_nxt = 1'b1;
      end else begin
        skid_data_nxt = res;
        skid_v_nxt    = 1'b1;
      end
    end else if (take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_v_r    <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      skid_v_r    <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_valid_r)
    else $error("skid word held without a result word");

  a_date_sane: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.cur_month != 4'd0) && (out_data_r.cur_month <= MONTHS)
                    && (out_data_r.cur_day != 5'd0))
    else $error("result date out of range");

  a_midnight: assert property (@(posedge clk) disable iff (!rst_n)
    acc && day_step |-> (tod_nxt == '0) && !rejected)
    else $error("date advanced without time wrapping to midnight");

  a_hold_on_reject: assert property (@(posedge clk) disable iff (!rst_n)
    acc && rejected |-> (date_nxt == u_date.date_r))
    else $error("rejected set changed the date");

endmodule

FILE: test/rtc_calendar_counter_checker.sv
`timescale 1ns / 1ps
module rtc_calendar_counter_checker import rtc_cal_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_item_t   out_data,
  output int unsigned mismatches,
  output int unsigned awaited
);

  localparam int unsigned DAY_SECS  = 86400;
  localparam int unsigned SHOW_MAX  = 40;

  logic [16:0] clock_secs;
  logic [4:0]  cal_day;
  logic [3:0]  cal_month;
  logic [15:0] cal_year;
  out_item_t   due_q[$];
  out_item_t   next_due;
  out_item_t   oldest_due;

  initial begin
    mismatches = 0;
    awaited    = 0;
  end

  task automatic report(input string msg);
    mismatches++;
    if (mismatches <= SHOW_MAX) $display("%0t ns  mismatch: %s", $time, msg);
  endtask

  function automatic bit leap_year(input logic [15:0] y);
    return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
  endfunction

  function automatic logic [4:0] month_days(input logic [3:0] m, input logic [15:0] y);
    case (m)
      4'd4, 4'd6, 4'd9, 4'd11: return 5'd30;
      4'd2:                    return leap_year(y) ? 5'd29 : 5'd28;
      default:                 return 5'd31;
    endcase
  endfunction

  task automatic roll_date();
    if (cal_day < month_days(cal_month, cal_year)) begin
      cal_day++;
    end else begin
      cal_day = 5'd1;
      if (cal_month >= 4'd12) begin
        cal_month = 4'd1;
        cal_year++;
      end else begin
        cal_month++;
      end
    end
  endtask

  // Update the calendar for one accepted word and form the result it must produce.
  task automatic apply_word(input in_item_t w, output out_item_t r);
    int unsigned t;
    int unsigned h;
    int unsigned m;
    int unsigned s;
    logic        rejected;
    rejected = 1'b0;
    case (w.kind)
      KIND_TICK: begin
        if (clock_secs >= DAY_SECS - 1) begin
          clock_secs = '0;
          roll_date();
        end else begin
          clock_secs++;
        end
      end
      KIND_SET: begin
        t = (32'(w.hour) * 3600 + 32'(w.minute) * 60) % DAY_SECS;
        clock_secs = 17'(t);
        if (w.day == 0 || w.month == 0 || w.month > 4'd12 ||
            w.day > month_days(w.month, w.year)) begin
          rejected = 1'b1;
        end else begin
          cal_day   = w.day;
          cal_month = w.month;
          cal_year  = w.year;
        end
      end
      default: ;
    endcase
    h = clock_secs / 3600;
    m = (clock_secs % 3600) / 60;
    s = clock_secs % 60;
    r.hour_tens     = 2'(h / 10);
    r.hour_ones     = 4'(h % 10);
    r.minute_tens   = 3'(m / 10);
    r.minute_ones   = 4'(m % 10);
    r.second_tens   = 3'(s / 10);
    r.second_ones   = 4'(s % 10);
    r.cur_day       = cal_day;
    r.cur_month     = cal_month;
    r.cur_year      = cal_year;
    r.date_rejected = rejected;
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want);
    if (got != want) report($sformatf("%s got %0d, expected %0d", name, got, want));
  endtask

  task automatic check_result(input out_item_t got, input out_item_t want);
    check_field("hour_tens",     got.hour_tens,     want.hour_tens);
    check_field("hour_ones",     got.hour_ones,     want.hour_ones);
    check_field("minute_tens",   got.minute_tens,   want.minute_tens);
    check_field("minute_ones",   got.minute_ones,   want.minute_ones);
    check_field("second_tens",   got.second_tens,   want.second_tens);
    check_field("second_ones",   got.second_ones,   want.second_ones);
    check_field("cur_day",       got.cur_day,       want.cur_day);
    check_field("cur_month",     got.cur_month,     want.cur_month);
    check_field("cur_year",      got.cur_year,      want.cur_year);
    check_field("date_rejected", got.date_rejected, want.date_rejected);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clock_secs = '0;
      cal_day    = 5'd1;
      cal_month  = 4'd1;
      cal_year   = '0;
      due_q.delete();
    end else begin
      // a result leaving at this edge always belongs to an earlier word
      if (out_valid && !out_stall) begin
        if (due_q.size() == 0) begin
          report("result word with nothing expected");
        end else begin
          oldest_due = due_q.pop_front();
          check_result(out_data, oldest_due);
        end
      end
      if (in_valid && !in_stall) begin
        apply_word(in_data, next_due);
        due_q.push_back(next_due);
      end
    end
    awaited <= due_q.size();
  end

endmodule

FILE: test/rtc_calendar_counter_tb.sv
`timescale 1ns / 1ps
module rtc_calendar_counter_tb;
  import rtc_cal_pkg::*;

  localparam logic [1:0]  KIND_READ  = 2'd2;
  localparam logic [1:0]  KIND_SPARE = 2'd3;
  localparam int unsigned WORD_COUNT = 1700;
  localparam int unsigned CALM_AFTER = 1500;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  int unsigned mismatches;
  int unsigned awaited;
  int unsigned sent = 0;
  bit          quiet = 1'b0;
  int          stall_run = 0;

  always #6 clk = ~clk;

  rtc_calendar_counter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  rtc_calendar_counter_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .mismatches (mismatches),
    .awaited    (awaited)
  );

  // Hold back results in bursts; none once the run calms down.
  always @(negedge clk) begin
    if (quiet) begin
      stall_run = 0;
    end else if (stall_run > 0) begin
      stall_run--;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_run = $urandom_range(1, 9);
    end
    out_stall <= (stall_run > 0);
  end

  initial begin
    #5_000_000;
    $display("rtc_calendar_counter_tb failed");
    $finish;
  end

  function automatic in_item_t plain_word(input logic [1:0] kind);
    in_item_t w;
    w.kind   = kind;
    w.hour   = 5'($urandom_range(0, 31));
    w.minute = 6'($urandom_range(0, 63));
    w.day    = 5'($urandom_range(0, 31));
    w.month  = 4'($urandom_range(0, 15));
    w.year   = 16'($urandom_range(0, 65535));
    return w;
  endfunction

  function automatic in_item_t set_word(input int unsigned h, input int unsigned m,
                                        input int unsigned d, input int unsigned mo,
                                        input int unsigned y);
    in_item_t w;
    w.kind   = KIND_SET;
    w.hour   = 5'(h);
    w.minute = 6'(m);
    w.day    = 5'(d);
    w.month  = 4'(mo);
    w.year   = 16'(y);
    return w;
  endfunction

  function automatic logic [15:0] pick_year();
    case ($urandom_range(0, 7))
      0:       return 16'hFFFF;
      1:       return 16'd1900;
      2:       return 16'd2000;
      3:       return 16'd2100;
      4:       return 16'd2400;
      5:       return {14'($urandom_range(0, 16383)), 2'b00};
      6:       return 16'(100 * $urandom_range(0, 655));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Present one word after an optional gap and hold it until taken; ends on a falling edge.
  task automatic send_word(input in_item_t w);
    int unsigned gap;
    int unsigned i;
    quiet = (sent >= CALM_AFTER);
    gap = (!quiet && $urandom_range(0, 4) == 0) ? $urandom_range(1, 9) : 0;
    for (i = 0; i < gap; i++) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    sent++;
    @(negedge clk);
  endtask

  // Set a time in the last hour before midnight, often near a month end, then send ticks toward midnight.
  task automatic run_to_midnight();
    int unsigned ticks;
    int unsigned done;
    int unsigned mo;
    int unsigned dy;
    logic [15:0] yr;
    if ($urandom_range(0, 3) == 0) begin
      mo = 12;
      dy = 31;
      yr = $urandom_range(0, 1) ? 16'hFFFF : pick_year();
    end else begin
      mo = ($urandom_range(0, 3) == 0) ? 2 : $urandom_range(1, 12);
      dy = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 31) : $urandom_range(28, 31);
      yr = pick_year();
    end
    send_word(set_word(23, ($urandom_range(0, 4) == 0) ? $urandom_range(0, 59) : 59,
                       dy, mo, yr));
    ticks = $urandom_range(58, 64);
    done  = 0;
    while (done < ticks) begin
      if ($urandom_range(0, 7) == 0) begin
        send_word(plain_word(KIND_READ));
      end else begin
        send_word(plain_word(KIND_TICK));
        done++;
      end
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_word(plain_word(KIND_READ));
    send_word(plain_word(KIND_TICK));
    send_word(plain_word(KIND_SPARE));
    send_word(set_word(31, 63, 31, 12, 65535));  // time wraps past 23:59; the date stays as set
    send_word(set_word(23, 59, 0, 5, 2000));     // day zero
    send_word(set_word(0, 0, 31, 4, 2001));      // 31st of a 30-day month
    send_word(set_word(12, 30, 31, 11, 2001));
    send_word(set_word(1, 1, 29, 2, 2000));      // leap by the 400 rule
    send_word(set_word(2, 2, 29, 2, 1900));      // century, not leap
    send_word(set_word(3, 3, 29, 2, 2024));
    send_word(set_word(4, 4, 29, 2, 2023));
    send_word(set_word(5, 5, 30, 2, 2000));
    send_word(set_word(6, 6, 10, 0, 2000));      // month zero
    send_word(set_word(7, 7, 10, 13, 2000));
    send_word(set_word(8, 8, 31, 15, 2000));
    send_word(set_word(9, 9, 31, 1, 0));
    send_word(set_word(10, 10, 29, 2, 0));
    send_word(plain_word(KIND_READ));
    send_word(set_word(0, 0, 1, 1, 65535));
    send_word(plain_word(KIND_TICK));
    send_word(set_word(24, 0, 31, 3, 2100));
    send_word(plain_word(KIND_SPARE));

    while (sent < WORD_COUNT) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: run_to_midnight();
        5, 6: begin
          send_word(set_word($urandom_range(0, 31), $urandom_range(0, 63),
                             $urandom_range(0, 31), $urandom_range(0, 15),
                             $urandom_range(0, 65535)));
          repeat ($urandom_range(1, 5)) send_word(plain_word(KIND_TICK));
        end
        default: repeat ($urandom_range(1, 20)) send_word(plain_word(2'($urandom_range(0, 3))));
      endcase
    end
    in_valid <= 1'b0;

    while (awaited != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("rtc_calendar_counter_tb passed");
    end else begin
      $display("rtc_calendar_counter_tb failed");
    end
    $finish;
  end

endmodule
